[rtl/core/twd_pkg.sv]
`default_nettype none
package twd_pkg;

    // dictionary geometry
    localparam int NODE_COUNT  = 4096;
    localparam int SYMBOLS     = 27;
    localparam int CHILD_DEPTH = NODE_COUNT * SYMBOLS;

    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int FREE_W  = $clog2(NODE_COUNT + 1);
    localparam int ADDR_W  = $clog2(CHILD_DEPTH);
    localparam int SYM_W   = 5;
    localparam int COUNT_W = 24;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_APOS = SYM_W'(26);
    localparam logic [SYM_W-1:0] SYM_BAD  = SYM_W'(SYMBOLS);

    // result status codes
    typedef logic [2:0] t_status;
    localparam t_status ST_PENDING   = 3'd0;
    localparam t_status ST_FOUND     = 3'd1;
    localparam t_status ST_NOT_FOUND = 3'd2;
    localparam t_status ST_INSERTED  = 3'd3;
    localparam t_status ST_FULL      = 3'd4;
    localparam t_status ST_BAD_CHAR  = 3'd5;

    // failure kinds kept for the current word
    localparam logic KIND_BAD_CHAR = 1'b0;
    localparam logic KIND_NO_NODE  = 1'b1;

endpackage
`default_nettype wire

[rtl/core/trie_word_dictionary.sv]
`default_nettype none
// Character-serial trie dictionary over 27 symbols (letters in either case and the
// apostrophe). A character word is taken when start is high and busy is low; each one
// gives exactly one result on o_status and o_word_count, shown for a single cycle with
// o_strobe, and the receiver cannot hold it off. Each character is handled as a child-table
// read, then update and result; the final character of a lookup also reads the
// end-of-word mark of the reached node from its own memory afterwards. After reset busy
// stays high while the child-table memory and end-mark memory are swept clear.
module trie_word_dictionary (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_mode,
    input  wire logic [7:0]  i_char_code,
    input  wire logic        i_last_char,
    output logic             o_strobe,
    output logic [2:0]       o_status,
    output logic [23:0]      o_word_count
);

    localparam int NODE_W  = twd_pkg::NODE_W;
    localparam int FREE_W  = twd_pkg::FREE_W;
    localparam int ADDR_W  = twd_pkg::ADDR_W;
    localparam int SYM_W   = twd_pkg::SYM_W;
    localparam int COUNT_W = twd_pkg::COUNT_W;

    localparam logic [1:0] S_CLR  = 2'd0;
    localparam logic [1:0] S_IDLE = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_MARK = 2'd3;

    localparam logic [ADDR_W-1:0]  SYM_MUL   = ADDR_W'(twd_pkg::SYMBOLS);
    localparam logic [ADDR_W-1:0]  CLR_LAST  = ADDR_W'(twd_pkg::CHILD_DEPTH - 1);
    localparam logic [ADDR_W-1:0]  CLR_MARKS = ADDR_W'(twd_pkg::NODE_COUNT);
    localparam logic [FREE_W-1:0]  FREE_FULL = FREE_W'(twd_pkg::NODE_COUNT);
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // map a raw byte to its symbol, or the bad-symbol code
    function automatic logic [SYM_W-1:0] sym_of(input logic [7:0] ch);
        logic [7:0] d;
        d = 8'h00;
        if (ch == 8'h27) begin
            return twd_pkg::SYM_APOS;
        end else if (ch >= 8'h41 && ch <= 8'h5A) begin
            d = ch - 8'h41;
            return d[SYM_W-1:0];
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            d = ch - 8'h61;
            return d[SYM_W-1:0];
        end
        return twd_pkg::SYM_BAD;
    endfunction

    logic [1:0]         r_state,    n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [NODE_W-1:0]  r_node,     n_node;
    logic [FREE_W-1:0]  r_free,     n_free;
    logic               r_failed,   n_failed;
    logic               r_kind,     n_kind;
    logic [COUNT_W-1:0] r_words,    n_words;
    logic               r_mode,     n_mode;
    logic               r_last,     n_last;
    logic               r_go,       n_go;
    logic [ADDR_W-1:0]  r_addr,     n_addr;
    logic               r_strobe,   n_strobe;
    logic [2:0]         r_status,   n_status;

    logic               accept;
    logic [SYM_W-1:0]   sym;
    logic               sym_bad;
    logic [ADDR_W-1:0]  slot;
    logic [NODE_W-1:0]  child;
    logic               missing;
    logic               full;
    logic               fail_now;
    logic               alloc;
    logic [NODE_W-1:0]  new_node;
    logic               eff_failed;
    logic               eff_kind;

    logic               child_we;
    logic [ADDR_W-1:0]  child_waddr;
    logic [NODE_W-1:0]  child_wdata;
    logic [NODE_W-1:0]  child_rdata;
    logic               mark_we;
    logic [NODE_W-1:0]  mark_waddr;
    logic               mark_wdata;
    logic               mark_re;
    logic               mark_rdata;

    // character decode and child slot address
    assign accept  = start && !busy;
    assign sym     = sym_of(i_char_code);
    assign sym_bad = (sym == twd_pkg::SYM_BAD);
    assign slot    = (ADDR_W'(r_node) * SYM_MUL) + ADDR_W'(sym);

    // step decision on the child read back
    assign child    = child_rdata;
    assign missing  = (child == '0);
    assign full     = (r_free == FREE_FULL);
    assign fail_now = r_go && missing && (r_mode || full);
    assign alloc    = r_go && missing && !r_mode && !full;
    assign new_node = missing ? r_free[NODE_W-1:0] : child;
    assign eff_failed = r_failed || fail_now;
    assign eff_kind   = fail_now ? twd_pkg::KIND_NO_NODE : r_kind;

    // child-table write: clearing sweep or a fresh node link
    always_comb begin
        if (r_state == S_CLR) begin
            child_we    = 1'b1;
            child_waddr = r_clr_addr;
            child_wdata = '0;
        end else begin
            child_we    = (r_state == S_READ) && alloc;
            child_waddr = r_addr;
            child_wdata = r_free[NODE_W-1:0];
        end
    end

    // end-mark write: clearing sweep or an inserted word
    always_comb begin
        if (r_state == S_CLR) begin
            mark_we    = (r_clr_addr < CLR_MARKS);
            mark_waddr = r_clr_addr[NODE_W-1:0];
            mark_wdata = 1'b0;
        end else begin
            mark_we    = (r_state == S_READ) && r_last && !eff_failed && !r_mode;
            mark_waddr = new_node;
            mark_wdata = 1'b1;
        end
    end

    assign mark_re = (r_state == S_READ);

    twd_ram #(
        .WIDTH (NODE_W),
        .DEPTH (twd_pkg::CHILD_DEPTH)
    ) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_re    (accept),
        .i_raddr (slot),
        .o_rdata (child_rdata)
    );

    twd_ram #(
        .WIDTH (1),
        .DEPTH (twd_pkg::NODE_COUNT)
    ) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_re    (mark_re),
        .i_raddr (new_node),
        .o_rdata (mark_rdata)
    );

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_node     = r_node;
        n_free     = r_free;
        n_failed   = r_failed;
        n_kind     = r_kind;
        n_words    = r_words;
        n_mode     = r_mode;
        n_last     = r_last;
        n_go       = r_go;
        n_addr     = r_addr;
        n_strobe   = 1'b0;
        n_status   = r_status;
        unique case (r_state)
            S_CLR: begin
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mode  = i_mode;
                    n_last  = i_last_char;
                    n_go    = !r_failed && !sym_bad;
                    n_addr  = slot;
                    n_state = S_READ;
                    if (!r_failed && sym_bad) begin
                        n_failed = 1'b1;
                        n_kind   = twd_pkg::KIND_BAD_CHAR;
                    end
                end
            end
            S_READ: begin
                n_state = S_IDLE;
                if (alloc) begin
                    n_free = r_free + 1'b1;
                end
                if (r_go && !fail_now) begin
                    n_node = new_node;
                end
                n_failed = eff_failed;
                n_kind   = eff_kind;
                if (!r_last) begin
                    n_strobe = 1'b1;
                    n_status = twd_pkg::ST_PENDING;
                end else if (eff_failed) begin
                    n_strobe = 1'b1;
                    if (eff_kind == twd_pkg::KIND_BAD_CHAR) begin
                        n_status = twd_pkg::ST_BAD_CHAR;
                    end else begin
                        n_status = r_mode ? twd_pkg::ST_NOT_FOUND : twd_pkg::ST_FULL;
                    end
                    n_node   = '0;
                    n_failed = 1'b0;
                    n_kind   = twd_pkg::KIND_BAD_CHAR;
                end else if (r_mode) begin
                    n_state = S_MARK;
                end else begin
                    n_strobe = 1'b1;
                    n_status = twd_pkg::ST_INSERTED;
                    if (r_words != COUNT_MAX) begin
                        n_words = r_words + 1'b1;
                    end
                    n_node   = '0;
                    n_failed = 1'b0;
                    n_kind   = twd_pkg::KIND_BAD_CHAR;
                end
            end
            S_MARK: begin
                n_state  = S_IDLE;
                n_strobe = 1'b1;
                n_status = mark_rdata ? twd_pkg::ST_FOUND : twd_pkg::ST_NOT_FOUND;
                n_node   = '0;
                n_failed = 1'b0;
                n_kind   = twd_pkg::KIND_BAD_CHAR;
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_node     <= '0;
            r_free     <= FREE_W'(1);
            r_failed   <= 1'b0;
            r_kind     <= twd_pkg::KIND_BAD_CHAR;
            r_words    <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_node     <= n_node;
            r_free     <= n_free;
            r_failed   <= n_failed;
            r_kind     <= n_kind;
            r_words    <= n_words;
            r_strobe   <= n_strobe;
        end
    end

    // per-word payload
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_last   <= n_last;
        r_go     <= n_go;
        r_addr   <= n_addr;
        r_status <= n_status;
    end

    assign busy         = (r_state != S_IDLE);
    assign o_strobe     = r_strobe;
    assign o_status     = r_status;
    assign o_word_count = r_words;

endmodule
`default_nettype wire

[rtl/core/twd_ram.sv]
`default_nettype none
module twd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire
